// ----- rtl/mmf_pkg.sv -----
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared codes and the command type passed from the front end to the back end.
// ----------------------------------------------------------------------------
package mmf_pkg;

  localparam logic [1:0] OP_SEND     = 2'd0;
  localparam logic [1:0] OP_RECV_BLK = 2'd1;
  localparam logic [1:0] OP_RECV_NB  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [1:0] STATUS_BLOCKED = 2'd3;

  localparam int ID_W    = 16;
  localparam int TYPE_W  = 16;
  localparam int DLEN_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int OLEN_W  = 7;

  typedef struct packed {
    logic [1:0]        op;
    logic [ID_W-1:0]   sender_id;
    logic [TYPE_W-1:0] msg_type;
    logic [DLEN_W-1:0] declared_len;
    logic [BYTE_W-1:0] data_byte;
    logic              data_last;
  } cmd_t;

endpackage

// ----- rtl/mmf_front.sv -----
// ----------------------------------------------------------------------------
// mmf_front
// Accepts input transactions, drops unknown ops and queues commands in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mmf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [mmf_pkg::ID_W-1:0]   sender_id,
  input  logic [mmf_pkg::TYPE_W-1:0] msg_type,
  input  logic [mmf_pkg::DLEN_W-1:0] declared_len,
  input  logic [mmf_pkg::BYTE_W-1:0] data_byte,
  input  logic                       data_last,
  output mmf_pkg::cmd_t              cmd,
  output logic                       cmd_valid,
  input  logic                       cmd_ready
);

  localparam logic [1:0] QLEN = 2'd2;

  mmf_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          op_known;
  logic          push;
  logic          pop;

  assign op_known = (op == mmf_pkg::OP_SEND) || (op == mmf_pkg::OP_RECV_BLK) ||
                    (op == mmf_pkg::OP_RECV_NB);
  assign in_ready  = (count != QLEN);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready && op_known;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op, sender_id: sender_id, msg_type: msg_type,
                     declared_len: declared_len, data_byte: data_byte,
                     data_last: data_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ----- rtl/mmf_back.sv -----
// ----------------------------------------------------------------------------
// mmf_back
// Carries out queued commands: stores sent messages in the header and payload
// memories, returns the oldest message as a run of byte results.
// ----------------------------------------------------------------------------
module mmf_back #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_BYTES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mmf_pkg::cmd_t              cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       woke_receiver,
  output logic [mmf_pkg::ID_W-1:0]   out_sender_id,
  output logic [mmf_pkg::TYPE_W-1:0] out_msg_type,
  output logic [mmf_pkg::OLEN_W-1:0] out_len,
  output logic [mmf_pkg::BYTE_W-1:0] out_byte,
  output logic                       byte_valid,
  output logic                       run_last
);

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W     = $clog2(PAYLOAD_BYTES + 1);
  localparam int MEM_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int HDR_W     = mmf_pkg::ID_W + mmf_pkg::TYPE_W + LEN_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HDR   = 2'd1;
  localparam logic [1:0] ST_BYTES = 2'd2;

  logic [HDR_W-1:0]          hmem [QUEUE_DEPTH];
  logic [mmf_pkg::BYTE_W-1:0] pmem [MEM_DEPTH];

  logic [1:0]       state;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [OCC_W-1:0] occ;
  logic             waiting;
  logic [LEN_W-1:0] send_offset;
  logic             send_rejected;
  logic [LEN_W-1:0] cur_len;
  logic [IDX_W-1:0] rx_slot;
  logic [HDR_W-1:0] hdr_q;
  logic [LEN_W-1:0] iss_idx;
  logic             rd_valid;
  logic             rd_last;
  logic [mmf_pkg::BYTE_W-1:0] rd_byte;

  logic             can_load;
  logic             is_empty;
  logic             is_full;
  logic             first;
  logic [LEN_W-1:0] dlen_clamp;
  logic             rej_now;
  logic [LEN_W-1:0] eff_len;
  logic             send_go;
  logic             recv_go;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W-1:0] hdr_len;
  logic             issue;
  logic             move;
  logic             hdr_empty_go;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;

  assign can_load = !out_valid || out_ready;
  assign is_empty = (occ == '0);
  assign is_full  = (occ == OCC_W'(QUEUE_DEPTH));
  assign first    = (send_offset == '0) && !send_rejected;
  assign dlen_clamp = (cmd.declared_len > mmf_pkg::DLEN_W'(PAYLOAD_BYTES)) ?
                      LEN_W'(PAYLOAD_BYTES) : cmd.declared_len[LEN_W-1:0];
  assign rej_now  = first ? is_full : send_rejected;
  assign eff_len  = first ? dlen_clamp : cur_len;

  assign cmd_ready = (state == ST_IDLE) && can_load;
  assign send_go   = cmd_valid && cmd_ready && (cmd.op == mmf_pkg::OP_SEND);
  assign recv_go   = cmd_valid && cmd_ready && (cmd.op != mmf_pkg::OP_SEND);

  assign wr_en   = send_go && !rej_now && (send_offset < eff_len);
  assign wr_addr = ADDR_W'(tail) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(send_offset);
  assign rd_addr = ADDR_W'(rx_slot) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(iss_idx);

  assign hdr_len      = hdr_q[LEN_W-1:0];
  assign hdr_empty_go = (state == ST_HDR) && (hdr_len == '0) && can_load;
  assign issue = (state == ST_BYTES) && (iss_idx != hdr_len) && (!rd_valid || can_load);
  assign move  = (state == ST_BYTES) && rd_valid && can_load;

  assign head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  // memories
  always_ff @(posedge clk) begin
    if (send_go && first && !is_full) begin
      hmem[tail] <= {cmd.sender_id, cmd.msg_type, dlen_clamp};
    end
    if (recv_go && !is_empty) begin
      hdr_q <= hmem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) pmem[wr_addr] <= cmd.data_byte;
    if (issue) begin
      rd_byte <= pmem[rd_addr];
      rd_last <= (iss_idx == hdr_len - 1'b1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      tail          <= '0;
      occ           <= '0;
      waiting       <= 1'b0;
      send_offset   <= '0;
      send_rejected <= 1'b0;
      cur_len       <= '0;
      rx_slot       <= '0;
      iss_idx       <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (send_go || (recv_go && is_empty) || hdr_empty_go || move) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (send_go) begin
        if (first) cur_len <= dlen_clamp;
        if (!rej_now && cmd.data_last) begin
          tail    <= tail_inc;
          occ     <= occ + 1'b1;
          waiting <= 1'b0;
        end
        if (cmd.data_last) begin
          send_offset   <= '0;
          send_rejected <= 1'b0;
        end else begin
          if (!rej_now && (send_offset < LEN_W'(PAYLOAD_BYTES))) begin
            send_offset <= send_offset + 1'b1;
          end
          send_rejected <= rej_now;
        end
      end

      if (recv_go) begin
        if (is_empty) begin
          if (cmd.op == mmf_pkg::OP_RECV_BLK) waiting <= 1'b1;
        end else begin
          rx_slot <= head;
          head    <= head_inc;
          occ     <= occ - 1'b1;
          state   <= ST_HDR;
        end
      end

      if (state == ST_HDR) begin
        iss_idx <= '0;
        if (hdr_len != '0) begin
          state <= ST_BYTES;
        end else if (can_load) begin
          state <= ST_IDLE;
        end
      end

      if (issue) iss_idx <= iss_idx + 1'b1;
      if (issue) rd_valid <= 1'b1;
      else if (move) rd_valid <= 1'b0;

      if (move && rd_last) state <= ST_IDLE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (send_go) begin
      status        <= rej_now ? mmf_pkg::STATUS_FULL : mmf_pkg::STATUS_OK;
      woke_receiver <= !rej_now && cmd.data_last && waiting;
      out_sender_id <= '0;
      out_msg_type  <= '0;
      out_len       <= '0;
      out_byte      <= '0;
      byte_valid    <= 1'b0;
      run_last      <= 1'b1;
    end else if (recv_go && is_empty) begin
      status        <= (cmd.op == mmf_pkg::OP_RECV_BLK) ? mmf_pkg::STATUS_BLOCKED :
                       mmf_pkg::STATUS_EMPTY;
      woke_receiver <= 1'b0;
      out_sender_id <= '0;
      out_msg_type  <= '0;
      out_len       <= '0;
      out_byte      <= '0;
      byte_valid    <= 1'b0;
      run_last      <= 1'b1;
    end else if (hdr_empty_go || move) begin
      status        <= mmf_pkg::STATUS_OK;
      woke_receiver <= 1'b0;
      out_sender_id <= hdr_q[HDR_W-1 -: mmf_pkg::ID_W];
      out_msg_type  <= hdr_q[LEN_W +: mmf_pkg::TYPE_W];
      out_len       <= mmf_pkg::OLEN_W'(hdr_len);
      out_byte      <= move ? rd_byte : '0;
      byte_valid    <= move;
      run_last      <= move ? rd_last : 1'b1;
    end
  end

endmodule

// ----- rtl/message_mailbox_fifo.sv -----
// a send, or a receive on an empty inbox, gets its result registered directly; a receive
// reads the header into a register, takes a start step (ending there for zero length),
// then moves each byte through a read register into the result register, one per cycle
// unless stalled; sends go one per cycle while the back end is idle (a receive holds it)
// and the result is not stalled; reset: synchronous; the mailbox comes up empty with no
// waiting receiver, store contents are left as they are and there is no clearing pass
// ----------------------------------------------------------------------------
// message_mailbox_fifo
// Single-inbox message mailbox: a front end queues commands, a back end stores
// and returns messages.
// ----------------------------------------------------------------------------
module message_mailbox_fifo #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_BYTES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [mmf_pkg::ID_W-1:0]   sender_id,
  input  logic [mmf_pkg::TYPE_W-1:0] msg_type,
  input  logic [mmf_pkg::DLEN_W-1:0] declared_len,
  input  logic [mmf_pkg::BYTE_W-1:0] data_byte,
  input  logic                       data_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       woke_receiver,
  output logic [mmf_pkg::ID_W-1:0]   out_sender_id,
  output logic [mmf_pkg::TYPE_W-1:0] out_msg_type,
  output logic [mmf_pkg::OLEN_W-1:0] out_len,
  output logic [mmf_pkg::BYTE_W-1:0] out_byte,
  output logic                       byte_valid,
  output logic                       run_last
);

  mmf_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  mmf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .sender_id    (sender_id),
    .msg_type     (msg_type),
    .declared_len (declared_len),
    .data_byte    (data_byte),
    .data_last    (data_last),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready)
  );

  mmf_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .woke_receiver (woke_receiver),
    .out_sender_id (out_sender_id),
    .out_msg_type  (out_msg_type),
    .out_len       (out_len),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .run_last      (run_last)
  );

endmodule

// ----- rtl/mmf_checker.sv -----
// ----------------------------------------------------------------------------
// mmf_checker
// Port-level checks on the result channel of the mailbox.
// ----------------------------------------------------------------------------
module mmf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 status,
  input logic                       woke_receiver,
  input logic [mmf_pkg::OLEN_W-1:0] out_len,
  input logic [mmf_pkg::BYTE_W-1:0] out_byte,
  input logic                       byte_valid,
  input logic                       run_last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status) &&
    $stable(run_last))
    else $error("result changed while stalled");

  // payload bytes only come with ok status and a nonzero length
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> status == mmf_pkg::STATUS_OK && out_len != '0 &&
    !woke_receiver)
    else $error("payload byte with bad status or length");

  // error and empty results are single-item runs
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mmf_pkg::STATUS_OK |-> run_last && !byte_valid &&
    !woke_receiver)
    else $error("error result not a single transaction");

  // wake only on a committed send
  a_wake: assert property (@(posedge clk) disable iff (rst)
    out_valid && woke_receiver |-> status == mmf_pkg::STATUS_OK && run_last &&
    out_len == '0)
    else $error("wake on non-send result");

endmodule

bind message_mailbox_fifo mmf_checker u_mmf_checker (.*);

// ----- verif/message_mailbox_fifo_checker.sv -----
// ----------------------------------------------------------------------------
// message_mailbox_fifo_checker
// Watches both transaction channels of the mailbox, keeps its own copy of the
// inbox (headers, payload bytes, pointers, waiting mark), works out the results
// that each accepted command causes and compares every returned result, field
// by field, with the oldest one still due. Hands the failure count and the
// number of results still due to the testbench top.
// ----------------------------------------------------------------------------
module message_mailbox_fifo_checker #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_BYTES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [mmf_pkg::ID_W-1:0]   sender_id,
  input  logic [mmf_pkg::TYPE_W-1:0] msg_type,
  input  logic [mmf_pkg::DLEN_W-1:0] declared_len,
  input  logic [mmf_pkg::BYTE_W-1:0] data_byte,
  input  logic                       data_last,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 status,
  input  logic                       woke_receiver,
  input  logic [mmf_pkg::ID_W-1:0]   out_sender_id,
  input  logic [mmf_pkg::TYPE_W-1:0] out_msg_type,
  input  logic [mmf_pkg::OLEN_W-1:0] out_len,
  input  logic [mmf_pkg::BYTE_W-1:0] out_byte,
  input  logic                       byte_valid,
  input  logic                       run_last,
  output int                         errors,
  output int                         pending
);

  typedef struct packed {
    logic [1:0]                 status;
    logic                       woke;
    logic [mmf_pkg::ID_W-1:0]   sid;
    logic [mmf_pkg::TYPE_W-1:0] typ;
    logic [mmf_pkg::OLEN_W-1:0] len;
    logic [mmf_pkg::BYTE_W-1:0] data;
    logic                       valid;
    logic                       last;
  } mail_result_t;

  mail_result_t               mail_results_due[$];
  logic [mmf_pkg::ID_W-1:0]   box_sid   [QUEUE_DEPTH];
  logic [mmf_pkg::TYPE_W-1:0] box_type  [QUEUE_DEPTH];
  logic [mmf_pkg::OLEN_W-1:0] box_len   [QUEUE_DEPTH];
  logic [mmf_pkg::BYTE_W-1:0] box_bytes [QUEUE_DEPTH][PAYLOAD_BYTES];
  int                         head_slot;
  int                         tail_slot;
  int                         msg_count;
  int                         fill_offset;
  logic                       waiting_rx;
  logic                       run_refused;

  function automatic mail_result_t mail_result(input logic [1:0] st, input logic wk,
      input logic [mmf_pkg::ID_W-1:0] sid, input logic [mmf_pkg::TYPE_W-1:0] typ,
      input logic [mmf_pkg::OLEN_W-1:0] len, input logic [mmf_pkg::BYTE_W-1:0] data,
      input logic vld, input logic lst);
    mail_result_t r;
    r.status = st;
    r.woke   = wk;
    r.sid    = sid;
    r.typ    = typ;
    r.len    = len;
    r.data   = data;
    r.valid  = vld;
    r.last   = lst;
    return r;
  endfunction

  task automatic predict_mail_results(input logic [1:0] code,
      input logic [mmf_pkg::ID_W-1:0] sid, input logic [mmf_pkg::TYPE_W-1:0] typ,
      input logic [mmf_pkg::DLEN_W-1:0] dlen, input logic [mmf_pkg::BYTE_W-1:0] b,
      input logic lst);
    int   n;
    int   i;
    logic refused;
    logic woke;
    case (code)
      mmf_pkg::OP_SEND: begin
        if (fill_offset == 0 && !run_refused) begin
          if (msg_count >= QUEUE_DEPTH) begin
            run_refused = 1'b1;
          end else begin
            box_sid[tail_slot]  = sid;
            box_type[tail_slot] = typ;
            box_len[tail_slot]  = (dlen > PAYLOAD_BYTES) ?
                                  mmf_pkg::OLEN_W'(PAYLOAD_BYTES) : mmf_pkg::OLEN_W'(dlen);
          end
        end
        refused = run_refused;
        woke    = 1'b0;
        if (!refused) begin
          if (fill_offset < box_len[tail_slot]) box_bytes[tail_slot][fill_offset] = b;
          if (fill_offset < PAYLOAD_BYTES) fill_offset++;
          if (lst) begin
            tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
            msg_count++;
            if (waiting_rx) begin
              waiting_rx = 1'b0;
              woke       = 1'b1;
            end
          end
        end
        if (lst) begin
          fill_offset = 0;
          run_refused = 1'b0;
        end
        mail_results_due.push_back(mail_result(
            refused ? mmf_pkg::STATUS_FULL : mmf_pkg::STATUS_OK, woke,
            '0, '0, '0, '0, 1'b0, 1'b1));
      end
      mmf_pkg::OP_RECV_BLK, mmf_pkg::OP_RECV_NB: begin
        if (msg_count == 0) begin
          if (code == mmf_pkg::OP_RECV_BLK) waiting_rx = 1'b1;
          mail_results_due.push_back(mail_result(
              (code == mmf_pkg::OP_RECV_BLK) ? mmf_pkg::STATUS_BLOCKED : mmf_pkg::STATUS_EMPTY,
              1'b0, '0, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          n = box_len[head_slot];
          if (n == 0) begin
            mail_results_due.push_back(mail_result(mmf_pkg::STATUS_OK, 1'b0,
                box_sid[head_slot], box_type[head_slot], '0, '0, 1'b0, 1'b1));
          end else begin
            for (i = 0; i < n; i++) begin
              mail_results_due.push_back(mail_result(mmf_pkg::STATUS_OK, 1'b0,
                  box_sid[head_slot], box_type[head_slot], box_len[head_slot],
                  box_bytes[head_slot][i], 1'b1, i == n - 1));
            end
          end
          head_slot = (head_slot + 1) % QUEUE_DEPTH;
          msg_count--;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_mail_result(input mail_result_t got);
    mail_result_t want;
    if (mail_results_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected: st %0d wk %0b id %h ty %h len %0d b %h v %0b l %0b",
                 got.status, got.woke, got.sid, got.typ, got.len, got.data, got.valid,
                 got.last);
    end else begin
      want = mail_results_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("expected: st %0d wk %0b id %h ty %h len %0d b %h v %0b l %0b",
                   want.status, want.woke, want.sid, want.typ, want.len, want.data,
                   want.valid, want.last);
          $display("actual:   st %0d wk %0b id %h ty %h len %0d b %h v %0b l %0b",
                   got.status, got.woke, got.sid, got.typ, got.len, got.data, got.valid,
                   got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_slot   = 0;
      tail_slot   = 0;
      msg_count   = 0;
      fill_offset = 0;
      waiting_rx  = 1'b0;
      run_refused = 1'b0;
      errors      = 0;
      mail_results_due.delete();
    end else begin
      if (in_valid && in_ready)
        predict_mail_results(op, sender_id, msg_type, declared_len, data_byte, data_last);
      if (out_valid && out_ready)
        check_mail_result(mail_result(status, woke_receiver, out_sender_id, out_msg_type,
                                      out_len, out_byte, byte_valid, run_last));
    end
    pending = mail_results_due.size();
  end

endmodule

// ----- verif/message_mailbox_fifo_test.sv -----
// ----------------------------------------------------------------------------
// message_mailbox_fifo_test
// Drives send and receive commands into the mailbox with random gaps on both
// channels: a directed opening (empty and blocked receives, waking a receiver,
// zero length, dropped bytes, a full inbox, an unused op), random message
// traffic with receives mixed into send runs, a long receiver hold-off that
// backs the block up, and an over-long run. A checker beside the block predicts
// and compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module message_mailbox_fifo_test;

  localparam int         QUEUE_DEPTH   = 16;
  localparam int         PAYLOAD_BYTES = 64;
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         IDLE_LIMIT    = 5000;
  localparam int         DRAIN_CYCLES  = 20;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  op = mmf_pkg::OP_SEND;
  logic [mmf_pkg::ID_W-1:0]    sender_id = '0;
  logic [mmf_pkg::TYPE_W-1:0]  msg_type = '0;
  logic [mmf_pkg::DLEN_W-1:0]  declared_len = '0;
  logic [mmf_pkg::BYTE_W-1:0]  data_byte = '0;
  logic                        data_last = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  status;
  logic                        woke_receiver;
  logic [mmf_pkg::ID_W-1:0]    out_sender_id;
  logic [mmf_pkg::TYPE_W-1:0]  out_msg_type;
  logic [mmf_pkg::OLEN_W-1:0]  out_len;
  logic [mmf_pkg::BYTE_W-1:0]  out_byte;
  logic                        byte_valid;
  logic                        run_last;

  int errors;
  int pending;
  int items_done  = 0;
  int hold_req    = 0;
  bit tx_steady   = 1'b0;
  int gen_occ     = 0;
  int gen_tail    = 0;
  int written_hw [QUEUE_DEPTH];
  int idle_cycles = 0;

  message_mailbox_fifo #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (.*);

  message_mailbox_fifo_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic drive_item(input logic [1:0] code, input logic [mmf_pkg::ID_W-1:0] sid,
      input logic [mmf_pkg::TYPE_W-1:0] typ, input logic [mmf_pkg::DLEN_W-1:0] dlen,
      input logic [mmf_pkg::BYTE_W-1:0] b, input logic lst);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    op           <= code;
    sender_id    <= sid;
    msg_type     <= typ;
    declared_len <= dlen;
    data_byte    <= b;
    data_last    <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (code != OP_UNUSED) items_done++;
  endtask

  task automatic receive_message(input bit blocking);
    drive_item(blocking ? mmf_pkg::OP_RECV_BLK : mmf_pkg::OP_RECV_NB, 16'($urandom),
               16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    if (gen_occ > 0) gen_occ--;
  endtask

  // early last is only allowed where the slot already holds written bytes up to
  // the stored length, so no never-written payload entry is ever read back
  task automatic send_message(input logic [mmf_pkg::ID_W-1:0] sid,
      input logic [mmf_pkg::TYPE_W-1:0] typ, input int dlen, input int nbytes,
      input int rx_mix);
    int stored;
    int written;
    int i;
    bit refused;
    stored  = (dlen > PAYLOAD_BYTES) ? PAYLOAD_BYTES : dlen;
    refused = (gen_occ >= QUEUE_DEPTH);
    if (!refused && nbytes < stored && written_hw[gen_tail] < stored) nbytes = stored;
    for (i = 0; i < nbytes; i++) begin
      if (i == 0)
        drive_item(mmf_pkg::OP_SEND, sid, typ, 16'(dlen), 8'($urandom), nbytes == 1);
      else
        drive_item(mmf_pkg::OP_SEND, 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), i == nbytes - 1);
      if (i < nbytes - 1 && rx_mix > 0 && $urandom_range(0, 99) < rx_mix) begin
        if ($urandom_range(0, 3) == 0)
          drive_item(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                     1'($urandom));
        else
          receive_message(1'($urandom));
      end
    end
    if (!refused) begin
      written = (nbytes < stored) ? nbytes : stored;
      if (written_hw[gen_tail] < written) written_hw[gen_tail] = written;
      gen_tail = (gen_tail + 1) % QUEUE_DEPTH;
      gen_occ++;
    end
  endtask

  task automatic random_send();
    int r;
    int dlen;
    int nbytes;
    int room;
    r = $urandom_range(0, 99);
    if (r < 75) dlen = $urandom_range(0, 4);
    else if (r < 95) dlen = $urandom_range(5, 12);
    else if (r < 98) dlen = $urandom_range(13, PAYLOAD_BYTES);
    else if (r < 99) dlen = $urandom_range(PAYLOAD_BYTES + 1, 65535);
    else dlen = 65535;
    nbytes = (dlen > PAYLOAD_BYTES) ? PAYLOAD_BYTES : dlen;
    if (nbytes == 0) nbytes = 1;
    room = written_hw[gen_tail];
    r = $urandom_range(0, 99);
    if (r >= 65 && r < 85) begin
      nbytes += $urandom_range(1, 4);
    end else if (r >= 85 && room >= 2) begin
      dlen   = $urandom_range(2, room);
      nbytes = $urandom_range(1, dlen - 1);
    end
    send_message(16'($urandom), 16'($urandom), dlen, nbytes, 10);
  endtask

  task automatic random_traffic(input int goal);
    int r;
    while (items_done < goal) begin
      r = $urandom_range(0, 99);
      if (r < 48)
        random_send();
      else if (r < 92)
        receive_message(1'($urandom));
      else
        drive_item(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   1'($urandom));
    end
  endtask

  // receiver side: random stalls, steady windows, and the long hold-off on request
  initial begin : receiver
    int stall;
    int served;
    int tick;
    stall  = 0;
    served = 0;
    tick   = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req != served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        served++;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ((tick % 700) >= 150) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("message_mailbox_fifo: mismatch");
      $finish;
    end
  end

  initial begin
    int i;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    receive_message(1'b0);
    receive_message(1'b1);
    send_message(16'hFFFF, 16'h0000, 0, 1, 0);
    send_message(16'h0000, 16'hFFFF, 3, 5, 0);
    for (i = 0; i < QUEUE_DEPTH - 2; i++)
      send_message(16'($urandom), 16'($urandom), 1, 1, 0);
    send_message(16'($urandom), 16'($urandom), 65535, 2, 0);
    drive_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    receive_message(1'b1);
    receive_message(1'b0);

    random_traffic(90);

    // inbox and command path back up while the receiver holds off
    hold_req++;
    tx_steady = 1'b1;
    repeat (32) send_message(16'($urandom), 16'($urandom), $urandom_range(0, 1), 1, 0);
    tx_steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (QUEUE_DEPTH) receive_message(1'($urandom));

    // write offset saturates past the payload size
    send_message(16'($urandom), 16'($urandom), 65535, PAYLOAD_BYTES + 3, 0);

    tx_steady = 1'b1;
    random_traffic(225);
    tx_steady = 1'b0;
    random_traffic(250);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("message_mailbox_fifo: match");
    else
      $display("message_mailbox_fifo: mismatch");
    $finish;
  end

endmodule
